>>> rtl/sgcd_pkg.sv
// ----------------------------------------------------------------------------
// Stick gesture command detector package
// Shared widths, word layouts, register indexes and stick patterns.
// ----------------------------------------------------------------------------
`default_nettype none

package sgcd_pkg;

   localparam int STICK_W    = 10;
   localparam int TIME_W     = 32;
   localparam int DELAY_W    = 16;
   localparam int PATTERN_W  = 8;
   localparam int SET_W      = 2;
   localparam int TRIM_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   // Request word layout, lowest bit first.
   localparam int REQ_THROTTLE_LSB = 0;
   localparam int REQ_ROLL_LSB     = 10;
   localparam int REQ_PITCH_LSB    = 20;
   localparam int REQ_YAW_LSB      = 30;
   localparam int REQ_NOW_LSB      = 40;
   localparam int REQ_ARMED_BIT    = 72;
   localparam int REQ_LANDED_BIT   = 73;
   localparam int REQ_SWITCH_BIT   = 74;
   localparam int REQ_GESTURE_BIT  = 75;

   // Response word layout, lowest bit first.
   localparam int RSP_SET_LSB     = 0;
   localparam int RSP_CHANGED_BIT = 2;
   localparam int RSP_TURN_BIT    = 3;
   localparam int RSP_ARMED_BIT   = 4;
   localparam int RSP_FB_LSB      = 5;
   localparam int RSP_LR_LSB      = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_HOLD_DELAY     = 2'd2,
      CSR_REPEAT_DELAY   = 2'd3
   } csr_index_type;

   localparam logic [STICK_W-1:0] LOW_THRESHOLD_RESET  = 10'd307;
   localparam logic [STICK_W-1:0] HIGH_THRESHOLD_RESET = 10'd716;
   localparam logic [DELAY_W-1:0] HOLD_DELAY_RESET     = 16'd2000;
   localparam logic [DELAY_W-1:0] REPEAT_DELAY_RESET   = 16'd100;

   typedef enum logic [2:0] {
      PHASE_MONITOR  = 3'b001,
      PHASE_CHANGING = 3'b010,
      PHASE_CHANGED  = 3'b100
   } phase_type;

   localparam logic [1:0] CODE_LO = 2'd1;
   localparam logic [1:0] CODE_HI = 2'd2;
   localparam logic [1:0] CODE_CE = 2'd3;

   // Patterns are {yaw, pitch, roll, throttle}.
   localparam logic [PATTERN_W-1:0] PAT_ARM      = {CODE_CE, CODE_CE, CODE_HI, CODE_LO};
   localparam logic [PATTERN_W-1:0] PAT_DISARM   = {CODE_CE, CODE_CE, CODE_LO, CODE_LO};
   localparam logic [PATTERN_W-1:0] PAT_TURN_ON  = PAT_ARM;
   localparam logic [PATTERN_W-1:0] PAT_TURN_OFF = PAT_DISARM;
   localparam logic [PATTERN_W-1:0] PAT_SET1     = {CODE_HI, CODE_LO, CODE_CE, CODE_LO};
   localparam logic [PATTERN_W-1:0] PAT_SET2     = {CODE_LO, CODE_LO, CODE_CE, CODE_LO};
   localparam logic [PATTERN_W-1:0] PAT_FB_UP    = {CODE_CE, CODE_HI, CODE_CE, CODE_LO};
   localparam logic [PATTERN_W-1:0] PAT_FB_DN    = {CODE_CE, CODE_LO, CODE_CE, CODE_LO};
   localparam logic [PATTERN_W-1:0] PAT_LR_DN    = {CODE_LO, CODE_CE, CODE_CE, CODE_LO};
   localparam logic [PATTERN_W-1:0] PAT_LR_UP    = {CODE_HI, CODE_CE, CODE_CE, CODE_LO};

   localparam logic [SET_W-1:0]  SET_ONE   = 2'd1;
   localparam logic [SET_W-1:0]  SET_TWO   = 2'd2;
   localparam logic [TRIM_W-1:0] TRIM_NONE = 2'sb00;
   localparam logic [TRIM_W-1:0] TRIM_UP   = 2'sb01;
   localparam logic [TRIM_W-1:0] TRIM_DOWN = 2'sb11;

endpackage

`default_nettype wire

>>> rtl/stick_gesture_command_detector_top.sv
// ----------------------------------------------------------------------------
// Stick gesture command detector
// Path: a request word is registered in the input stage and its result word in the output stage.
// Throughput: one word per cycle while the result stream is not stalled, limited by the single state update stage.
// Reset: synchronous; clears both pipeline stages, the hold tracker and the
// flags, and loads the threshold and delay registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_gesture_command_detector_top
   import sgcd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // throttle[9:0], roll[19:10], pitch[29:20], yaw[39:30], now_ms[71:40],
   // motors_armed[72], is_landed[73], arm_switch_on[74],
   // gesture_arming_enabled[75], zero[79:76]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // active_param_set[1:0], param_set_changed[2], turn_to_waypoint[3],
   // gesture_armed[4], trim_fore_aft_step[6:5], trim_left_right_step[8:7],
   // zero[15:9]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [STICK_W-1:0]   low_threshold_ff;
   logic [STICK_W-1:0]   high_threshold_ff;
   logic [DELAY_W-1:0]   hold_delay_ff;
   logic [DELAY_W-1:0]   repeat_delay_ff;

   logic                 in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;

   phase_type            phase_ff, phase_in;
   logic [PATTERN_W-1:0] held_ff, held_in;
   logic [TIME_W-1:0]    deadline_ff, deadline_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic                 turn_ff, turn_in;
   logic                 armed_ff, armed_in;

   logic                 out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic                 advance;
   logic                 move;

   logic [PATTERN_W-1:0] pattern;
   logic [TIME_W-1:0]    now_ms;
   logic                 motors_armed;
   logic                 is_landed;
   logic                 switch_on;
   logic                 gesture_en;
   logic [TIME_W-1:0]    elapsed;
   logic                 passed;
   phase_type            track_phase;
   logic [SET_W-1:0]     next_set;
   logic                 changed;
   logic [TRIM_W-1:0]    fb_step;
   logic [TRIM_W-1:0]    lr_step;

   assign csr_ready  = 1'b1;
   assign advance    = !out_valid_ff || rsp_tready;
   assign move       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff  <= LOW_THRESHOLD_RESET;
         high_threshold_ff <= HIGH_THRESHOLD_RESET;
         hold_delay_ff     <= HOLD_DELAY_RESET;
         repeat_delay_ff   <= REPEAT_DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_THRESHOLD:  low_threshold_ff  <= csr_data[STICK_W-1:0];
            CSR_HIGH_THRESHOLD: high_threshold_ff <= csr_data[STICK_W-1:0];
            CSR_HOLD_DELAY:     hold_delay_ff     <= csr_data;
            CSR_REPEAT_DELAY:   repeat_delay_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [STICK_W-1:0] stick;
      pattern = '0;
      for (int k = 0; k < 4; k++) begin
         stick = in_data_ff[REQ_THROTTLE_LSB + k*STICK_W +: STICK_W];
         pattern[2*k+1] = stick > low_threshold_ff;
         pattern[2*k]   = stick < high_threshold_ff;
      end
   end

   assign now_ms       = in_data_ff[REQ_NOW_LSB +: TIME_W];
   assign motors_armed = in_data_ff[REQ_ARMED_BIT];
   assign is_landed    = in_data_ff[REQ_LANDED_BIT];
   assign switch_on    = in_data_ff[REQ_SWITCH_BIT];
   assign gesture_en   = in_data_ff[REQ_GESTURE_BIT];
   assign elapsed      = now_ms - deadline_ff;
   assign passed       = (elapsed != '0) && !elapsed[TIME_W-1];

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      deadline_in = deadline_ff;
      set_in      = set_ff;
      turn_in     = turn_ff;
      armed_in    = armed_ff;
      track_phase = phase_ff;
      next_set    = set_ff;
      changed     = 1'b0;
      fb_step     = TRIM_NONE;
      lr_step     = TRIM_NONE;

      unique case (phase_ff)
         PHASE_MONITOR: begin
            if (held_ff != pattern) begin
               held_in     = pattern;
               deadline_in = now_ms + TIME_W'(hold_delay_ff);
               track_phase = PHASE_CHANGING;
            end
         end
         PHASE_CHANGING: begin
            if (held_ff == pattern) begin
               if (passed) begin
                  track_phase = PHASE_CHANGED;
               end
            end else begin
               track_phase = PHASE_MONITOR;
            end
         end
         default: ;
      endcase

      if (!motors_armed) begin
         phase_in = track_phase;
         if (track_phase == PHASE_CHANGED) begin
            if (gesture_en && held_in == PAT_ARM && switch_on && !armed_ff) begin
               armed_in = 1'b1;
            end else begin
               if (held_in == PAT_TURN_ON) begin
                  turn_in = 1'b1;
               end else if (held_in == PAT_TURN_OFF) begin
                  turn_in = 1'b0;
               end else if (held_in == PAT_SET1) begin
                  next_set = SET_ONE;
               end else if (held_in == PAT_SET2) begin
                  next_set = SET_TWO;
               end
               set_in  = next_set;
               changed = next_set != set_ff;
            end
            phase_in = PHASE_MONITOR;
         end
      end else if (is_landed) begin
         phase_in = track_phase;
         if (track_phase == PHASE_CHANGED) begin
            if (gesture_en && held_in == PAT_DISARM && armed_ff) begin
               armed_in = 1'b0;
               phase_in = PHASE_MONITOR;
            end else begin
               if (held_in == PAT_FB_UP) begin
                  fb_step = TRIM_UP;
               end else if (held_in == PAT_FB_DN) begin
                  fb_step = TRIM_DOWN;
               end else if (held_in == PAT_LR_DN) begin
                  lr_step = TRIM_DOWN;
               end else if (held_in == PAT_LR_UP) begin
                  lr_step = TRIM_UP;
               end
               if (fb_step != TRIM_NONE || lr_step != TRIM_NONE) begin
                  phase_in    = PHASE_CHANGING;
                  deadline_in = now_ms + TIME_W'(repeat_delay_ff);
               end else begin
                  phase_in = PHASE_MONITOR;
               end
            end
         end
      end else begin
         held_in     = held_ff;
         deadline_in = deadline_ff;
         phase_in    = PHASE_MONITOR;
      end

      out_data_in = {7'b0, lr_step, fb_step, armed_in, turn_in, changed, set_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PHASE_MONITOR;
         held_ff      <= '0;
         deadline_ff  <= '0;
         set_ff       <= SET_ONE;
         turn_ff      <= 1'b1;
         armed_ff     <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            held_ff      <= held_in;
            deadline_ff  <= deadline_in;
            set_ff       <= set_in;
            turn_ff      <= turn_in;
            armed_ff     <= armed_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (move) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sgcd_checker.sv
// ----------------------------------------------------------------------------
// Stick gesture command detector checker
// Port level assertions on the result stream and the request ready, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgcd_checker
   import sgcd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [SET_W-1:0]  set_seen;
   logic [TRIM_W-1:0] fb_seen;
   logic [TRIM_W-1:0] lr_seen;

   assign set_seen = rsp_tdata[RSP_SET_LSB +: SET_W];
   assign fb_seen  = rsp_tdata[RSP_FB_LSB +: TRIM_W];
   assign lr_seen  = rsp_tdata[RSP_LR_LSB +: TRIM_W];

   // The selected parameter set is always one or two.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (set_seen == SET_ONE || set_seen == SET_TWO))
      else $error("parameter set out of range");

   // At most one trim axis steps in a word, and only by one unit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fb_seen == TRIM_NONE || lr_seen == TRIM_NONE) &&
                     fb_seen != 2'b10 && lr_seen != 2'b10)
      else $error("illegal trim step");

   // An empty result stage never holds back the request side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result stage");

   // A stalled result word stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

endmodule

bind stick_gesture_command_detector_top sgcd_checker u_sgcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> verif/stick_gesture_command_detector_top_tb.sv
// ----------------------------------------------------------------------------
// Stick gesture command detector testbench
// Drives stick sample words through the request stream and checks every
// response word against a cycle-free model of the hold tracker, the command
// decode and the trim auto-repeat. Directed gestures cover every command, the
// arming corner cases, crossed thresholds and the millisecond clock wrap;
// random gestures then run under several register settings with random
// stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------

module stick_gesture_command_detector_top_tb;
   import sgcd_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic                gesture_en;
      logic                arm_sw;
      logic                landed;
      logic                armed;
      logic [TIME_W-1:0]   now;
      logic [STICK_W-1:0]  yaw;
      logic [STICK_W-1:0]  pitch;
      logic [STICK_W-1:0]  roll;
      logic [STICK_W-1:0]  throttle;
   } stick_sample_type;

   typedef struct packed {
      logic [TRIM_W-1:0] lr;
      logic [TRIM_W-1:0] fb;
      logic              armed;
      logic              turn;
      logic              changed;
      logic [SET_W-1:0]  set;
   } gesture_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   csr_index_type         csr_index  = CSR_LOW_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_ready;

   logic [STICK_W-1:0]    low_th     = LOW_THRESHOLD_RESET;
   logic [STICK_W-1:0]    high_th    = HIGH_THRESHOLD_RESET;
   logic [DELAY_W-1:0]    hold_ms    = HOLD_DELAY_RESET;
   logic [DELAY_W-1:0]    repeat_ms  = REPEAT_DELAY_RESET;
   phase_type             phase      = PHASE_MONITOR;
   logic [PATTERN_W-1:0]  held_pat   = '0;
   logic [TIME_W-1:0]     deadline   = '0;
   logic [SET_W-1:0]      param_set  = SET_ONE;
   logic                  turn_flag  = 1'b1;
   logic                  armed_flag = 1'b0;

   gesture_result_type    expected_results[$];
   int                    errors        = 0;
   int                    stall_cycles  = 0;
   int                    hold_off_left = 0;
   bit                    idle_on       = 1'b1;
   logic [TIME_W-1:0]     clock_ms      = '0;

   stick_gesture_command_detector_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [PATTERN_W-1:0] classify_sticks(stick_sample_type s);
      logic [STICK_W-1:0]   v [4];
      logic [PATTERN_W-1:0] pat;
      v[0] = s.throttle;
      v[1] = s.roll;
      v[2] = s.pitch;
      v[3] = s.yaw;
      pat = '0;
      for (int k = 0; k < 4; k++) begin
         pat[2*k+1] = v[k] > low_th;
         pat[2*k]   = v[k] < high_th;
      end
      return pat;
   endfunction

   function automatic bit deadline_passed(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] d;
      d = now - deadline;
      return d != '0 && !d[TIME_W-1];
   endfunction

   function automatic void track_pattern(logic [PATTERN_W-1:0] pat, logic [TIME_W-1:0] now);
      case (phase)
         PHASE_MONITOR: begin
            if (held_pat != pat) begin
               held_pat = pat;
               deadline = now + hold_ms;
               phase    = PHASE_CHANGING;
            end
         end
         PHASE_CHANGING: begin
            if (held_pat == pat) begin
               if (deadline_passed(now)) phase = PHASE_CHANGED;
            end else begin
               phase = PHASE_MONITOR;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic gesture_result_type predict_gesture(stick_sample_type s);
      logic [PATTERN_W-1:0] pat;
      logic [SET_W-1:0]     next_set;
      gesture_result_type   r;
      r    = '0;
      r.fb = TRIM_NONE;
      r.lr = TRIM_NONE;
      pat  = classify_sticks(s);
      if (!s.armed) begin
         track_pattern(pat, s.now);
         if (phase == PHASE_CHANGED) begin
            if (s.gesture_en && held_pat == PAT_ARM && s.arm_sw && !armed_flag) begin
               armed_flag = 1'b1;
            end else begin
               next_set = param_set;
               if (held_pat == PAT_TURN_ON) turn_flag = 1'b1;
               else if (held_pat == PAT_TURN_OFF) turn_flag = 1'b0;
               else if (held_pat == PAT_SET1) next_set = SET_ONE;
               else if (held_pat == PAT_SET2) next_set = SET_TWO;
               if (next_set != param_set) begin
                  param_set = next_set;
                  r.changed = 1'b1;
               end
            end
            phase = PHASE_MONITOR;
         end
      end else if (s.landed) begin
         track_pattern(pat, s.now);
         if (phase == PHASE_CHANGED) begin
            if (s.gesture_en && held_pat == PAT_DISARM && armed_flag) begin
               armed_flag = 1'b0;
               phase      = PHASE_MONITOR;
            end else begin
               if (held_pat == PAT_FB_UP) r.fb = TRIM_UP;
               else if (held_pat == PAT_FB_DN) r.fb = TRIM_DOWN;
               else if (held_pat == PAT_LR_DN) r.lr = TRIM_DOWN;
               else if (held_pat == PAT_LR_UP) r.lr = TRIM_UP;
               if (r.fb != TRIM_NONE || r.lr != TRIM_NONE) begin
                  phase    = PHASE_CHANGING;
                  deadline = s.now + repeat_ms;
               end else begin
                  phase = PHASE_MONITOR;
               end
            end
         end
      end else begin
         phase = PHASE_MONITOR;
      end
      r.set   = param_set;
      r.turn  = turn_flag;
      r.armed = armed_flag;
      return r;
   endfunction

   function automatic logic [STICK_W-1:0] stick_for_code(logic [1:0] code);
      int lo_b;
      int hi_b;
      int l;
      int h;
      int r;
      l = low_th;
      h = high_th;
      case (code)
         CODE_LO: begin
            lo_b = 0;
            hi_b = (l < h - 1) ? l : h - 1;
         end
         CODE_HI: begin
            lo_b = (l + 1 > h) ? l + 1 : h;
            hi_b = 1023;
         end
         CODE_CE: begin
            lo_b = l + 1;
            hi_b = h - 1;
         end
         default: begin
            lo_b = h;
            hi_b = l;
         end
      endcase
      if (lo_b > hi_b) return STICK_W'($urandom_range(0, 1023));
      r = $urandom_range(0, 7);
      if (r == 0) return STICK_W'(lo_b);
      if (r == 1) return STICK_W'(hi_b);
      return STICK_W'($urandom_range(lo_b, hi_b));
   endfunction

   function automatic stick_sample_type sample_for(logic [PATTERN_W-1:0] pattern, logic armed,
                                                   logic landed, logic arm_sw,
                                                   logic gesture_en, logic [TIME_W-1:0] now);
      stick_sample_type s;
      s.throttle   = stick_for_code(pattern[1:0]);
      s.roll       = stick_for_code(pattern[3:2]);
      s.pitch      = stick_for_code(pattern[5:4]);
      s.yaw        = stick_for_code(pattern[7:6]);
      s.now        = now;
      s.armed      = armed;
      s.landed     = landed;
      s.arm_sw     = arm_sw;
      s.gesture_en = gesture_en;
      return s;
   endfunction

   function automatic logic [PATTERN_W-1:0] pick_pattern();
      case ($urandom_range(0, 9))
         0:       return PAT_ARM;
         1:       return PAT_DISARM;
         2:       return PAT_SET1;
         3:       return PAT_SET2;
         4:       return PAT_FB_UP;
         5:       return PAT_FB_DN;
         6:       return PAT_LR_DN;
         7:       return PAT_LR_UP;
         default: return PATTERN_W'($urandom);
      endcase
   endfunction

   function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   task automatic send_sample(stick_sample_type s);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < 35) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {{(REQ_DATA_W - $bits(stick_sample_type)){1'b0}}, s};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_gesture(s));
   endtask

   task automatic hold_gesture(logic [PATTERN_W-1:0] pattern, logic armed, logic landed,
                               logic arm_sw, logic gesture_en, int count, int min_step,
                               int max_step);
      repeat (count) begin
         clock_ms = clock_ms + $urandom_range(min_step, max_step);
         send_sample(sample_for(pattern, armed, landed, arm_sw, gesture_en, clock_ms));
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LOW_THRESHOLD:  low_th    = value[STICK_W-1:0];
         CSR_HIGH_THRESHOLD: high_th   = value[STICK_W-1:0];
         CSR_HOLD_DELAY:     hold_ms   = value;
         CSR_REPEAT_DELAY:   repeat_ms = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // The threshold registers ignore the upper data bits, so those carry noise.
   task automatic configure_detector(int lo, int hi, int hold, int rep);
      drain_results();
      write_register(CSR_LOW_THRESHOLD, {6'($urandom), STICK_W'(lo)});
      write_register(CSR_HIGH_THRESHOLD, {6'($urandom), STICK_W'(hi)});
      write_register(CSR_HOLD_DELAY, DELAY_W'(hold));
      write_register(CSR_REPEAT_DELAY, DELAY_W'(rep));
   endtask

   task automatic run_random_phase(int item_count);
      int                   sent;
      int                   mode;
      int                   count;
      logic [95:0]          raw;
      logic                 armed;
      logic                 landed;
      sent = 0;
      while (sent < item_count) begin
         if ($urandom_range(0, 29) == 0) clock_ms = $urandom;
         if ($urandom_range(0, 99) < 12) begin
            raw = {$urandom, $urandom, $urandom};
            send_sample(raw[$bits(stick_sample_type)-1:0]);
            sent++;
         end else begin
            mode   = $urandom_range(0, 9);
            armed  = mode >= 5;
            landed = (mode < 5) ? 1'($urandom_range(0, 1)) : (mode < 9);
            count  = $urandom_range(1, 12);
            hold_gesture(pick_pattern(), armed, landed, $urandom_range(0, 3) != 0,
                         $urandom_range(0, 3) != 0, count, 0, hold_ms / 3 + 1);
            sent += count;
         end
      end
   endtask

   // Zero delays let a command fire on the second word; the time base wraps
   // part way through.
   task automatic test_command_gestures();
      configure_detector(LOW_THRESHOLD_RESET, HIGH_THRESHOLD_RESET, 0, 0);
      clock_ms = 32'hFFFF_FFF0;
      hold_gesture(PAT_SET2,     1'b0, 1'b0, 1'b1, 1'b1, 2, 1, 1);
      hold_gesture(PAT_SET1,     1'b0, 1'b1, 1'b1, 1'b1, 2, 1, 1);
      hold_gesture(PAT_TURN_OFF, 1'b0, 1'b0, 1'b1, 1'b1, 2, 1, 1);
      hold_gesture(PAT_ARM,      1'b0, 1'b0, 1'b0, 1'b1, 2, 1, 1);
      hold_gesture(PAT_TURN_OFF, 1'b0, 1'b0, 1'b1, 1'b1, 2, 1, 1);
      hold_gesture(PAT_ARM,      1'b0, 1'b1, 1'b1, 1'b1, 2, 1, 1);
      hold_gesture(PAT_DISARM,   1'b1, 1'b1, 1'b1, 1'b0, 2, 1, 1);
      hold_gesture(PAT_FB_UP,    1'b1, 1'b1, 1'b1, 1'b1, 3, 1, 1);
      hold_gesture(PAT_FB_DN,    1'b1, 1'b1, 1'b1, 1'b1, 3, 1, 1);
      hold_gesture(PAT_LR_DN,    1'b1, 1'b1, 1'b1, 1'b1, 3, 1, 1);
      hold_gesture(PAT_LR_UP,    1'b1, 1'b1, 1'b1, 1'b1, 3, 1, 1);
      hold_gesture(PAT_DISARM,   1'b1, 1'b1, 1'b1, 1'b1, 3, 1, 1);
      hold_gesture(PAT_FB_UP,    1'b1, 1'b0, 1'b1, 1'b1, 2, 1, 1);
   endtask

   task automatic test_threshold_extremes();
      configure_detector(1023, 0, 0, 0);
      send_sample({4'b0000, 32'h0000_0000, {4{10'd0}}});
      send_sample({4'b1111, 32'hFFFF_FFFF, {4{10'd1023}}});
      configure_detector(0, 1023, 0, 0);
      send_sample({4'b0000, 32'h0000_0000, {4{10'd0}}});
      send_sample({4'b1111, 32'hFFFF_FFFF, {4{10'd1023}}});
   endtask

   task automatic test_output_stall();
      configure_detector(LOW_THRESHOLD_RESET, HIGH_THRESHOLD_RESET, 20, 5);
      idle_on = 1'b0;
      @(posedge clock);
      hold_off_left = HOLD_OFF_CYCLES;
      run_random_phase(60);
      idle_on = 1'b1;
   endtask

   task automatic test_random_settings();
      int lo;
      configure_detector(LOW_THRESHOLD_RESET, HIGH_THRESHOLD_RESET, HOLD_DELAY_RESET,
                         REPEAT_DELAY_RESET);
      run_random_phase(190);
      configure_detector(0, 1023, 0, 0);
      run_random_phase(190);
      lo = $urandom_range(0, 600);
      configure_detector(lo, $urandom_range(lo + 2, 1023), $urandom_range(0, 300),
                         $urandom_range(0, 100));
      idle_on = 1'b0;
      run_random_phase(190);
      idle_on = 1'b1;
      configure_detector(1023, 0, 50, 10);
      run_random_phase(190);
      configure_detector(100, 900, 65535, 65535);
      run_random_phase(190);
      configure_detector(511, 512, 30, 0);
      run_random_phase(190);
   endtask

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready = 1'b0;
         hold_off_left--;
      end else begin
         rsp_tready = !idle_on || ($urandom_range(0, 99) >= 35);
      end
   end

   always @(posedge clock) begin : result_check
      gesture_result_type want;
      gesture_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: response word %h expected none actual word", $time, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            got  = rsp_tdata[$bits(gesture_result_type)-1:0];
            check_field("active_param_set", want.set, got.set);
            check_field("param_set_changed", want.changed, got.changed);
            check_field("turn_to_waypoint", want.turn, got.turn);
            check_field("gesture_armed", want.armed, got.armed);
            check_field("trim_fore_aft_step", want.fb, got.fb);
            check_field("trim_left_right_step", want.lr, got.lr);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_command_gestures();
      test_threshold_extremes();
      test_output_stall();
      test_random_settings();
      drain_results();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
